// ===== hw/rtl/rlb_pkg.sv =====
// rlb_pkg: shared types and constants for the RLE sprite clipped blit.
// No dependencies; imported by every module of the block.

package rlb_pkg;

	localparam int MAX_DIM = 4096;

	localparam int CFG_W   = 13;
	localparam int COL_W   = 17;
	localparam int ROW_W   = 13;
	localparam int RUN_W   = 16;
	localparam int WORD_W  = 32;
	localparam int COORD_W = 12;
	localparam int IDX_W   = 3;

	localparam logic [COL_W-1:0] COL_MAX   = '1;
	localparam logic [CFG_W-1:0] MAX_DIM_C = CFG_W'(MAX_DIM);

	localparam logic [IDX_W-1:0] REG_DEST_WIDTH    = 3'd0;
	localparam logic [IDX_W-1:0] REG_DEST_HEIGHT   = 3'd1;
	localparam logic [IDX_W-1:0] REG_ORIGIN_X      = 3'd2;
	localparam logic [IDX_W-1:0] REG_ORIGIN_Y      = 3'd3;
	localparam logic [IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd4;
	localparam logic [IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd5;

	typedef struct packed {
		logic [CFG_W-1:0]        dest_width;
		logic [CFG_W-1:0]        dest_height;
		logic signed [CFG_W-1:0] origin_x;
		logic signed [CFG_W-1:0] origin_y;
		logic [CFG_W-1:0]        sprite_width;
		logic [CFG_W-1:0]        sprite_height;
	} cfg_t;

	typedef struct packed {
		logic               hit;
		logic [COORD_W-1:0] dest_x;
		logic [COORD_W-1:0] dest_y;
	} walk_res_t;

endpackage

// ===== hw/rtl/rlb_if.sv =====
// rlb_if: valid/ready channel interfaces for the code stream and pixel writes.
// Depends on rlb_pkg for field widths.

interface rlb_code_if;
	import rlb_pkg::*;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] code_word;

	modport source (output valid, output code_word, input ready);
	modport sink (input valid, input code_word, output ready);
endinterface

interface rlb_pix_if;
	import rlb_pkg::*;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] dest_x;
	logic [COORD_W-1:0] dest_y;
	logic [WORD_W-1:0]  pixel_value;

	modport source (output valid, output dest_x, output dest_y, output pixel_value,
		input ready);
	modport sink (input valid, input dest_x, input dest_y, input pixel_value,
		output ready);
endinterface

// ===== hw/rtl/rlb_cfg_regs.sv =====
// rlb_cfg_regs: configuration register file of the blit, plain write port.
// Depends on rlb_pkg.

module rlb_cfg_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [rlb_pkg::IDX_W-1:0] cfg_index,
	input  logic [rlb_pkg::CFG_W-1:0] cfg_data,
	output rlb_pkg::cfg_t             cfg
);
	import rlb_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_width    <= CFG_W'(320);
			cfg_q.dest_height   <= CFG_W'(240);
			cfg_q.origin_x      <= '0;
			cfg_q.origin_y      <= '0;
			cfg_q.sprite_width  <= CFG_W'(16);
			cfg_q.sprite_height <= CFG_W'(16);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_DEST_WIDTH:    cfg_q.dest_width    <= cfg_data;
				REG_DEST_HEIGHT:   cfg_q.dest_height   <= cfg_data;
				REG_ORIGIN_X:      cfg_q.origin_x      <= cfg_data;
				REG_ORIGIN_Y:      cfg_q.origin_y      <= cfg_data;
				REG_SPRITE_WIDTH:  cfg_q.sprite_width  <= cfg_data;
				REG_SPRITE_HEIGHT: cfg_q.sprite_height <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/rlb_walker.sv =====
// rlb_walker: sprite walk state (column, row, run) and the clip test for one word.
// Depends on rlb_pkg.

module rlb_walker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rlb_pkg::cfg_t              cfg,
	input  logic                       step,
	input  logic [rlb_pkg::WORD_W-1:0] word,
	output rlb_pkg::walk_res_t         res
);
	import rlb_pkg::*;

	logic [COL_W-1:0] column_q;
	logic [ROW_W-1:0] row_q;
	logic [RUN_W-1:0] run_left_q;
	logic             expect_hdr_q;

	logic [COL_W:0]   col_sum_hdr;
	logic [COL_W-1:0] col_hdr;
	logic [COL_W-1:0] col_pix;
	logic [COL_W-1:0] col_adv;
	logic [RUN_W-1:0] run_adv;
	logic             run_done;
	logic             row_end;
	logic [ROW_W:0]   row_inc;
	logic [COL_W-1:0] column_d;
	logic [ROW_W-1:0] row_d;

	logic signed [COL_W+1:0] dx;
	logic signed [ROW_W+1:0] dy;
	logic [CFG_W-1:0]        lim_w;
	logic [CFG_W-1:0]        lim_h;

	always_comb begin
		col_sum_hdr = {1'b0, column_q} + {{(COL_W+1-RUN_W){1'b0}}, word[31:16]};
		col_hdr     = col_sum_hdr[COL_W] ? COL_MAX : col_sum_hdr[COL_W-1:0];
		col_pix     = (column_q == COL_MAX) ? COL_MAX : column_q + COL_W'(1);

		if (expect_hdr_q) begin
			col_adv  = col_hdr;
			run_adv  = word[RUN_W-1:0];
			run_done = (word[RUN_W-1:0] == '0);
		end else begin
			col_adv  = col_pix;
			run_adv  = run_left_q - RUN_W'(1);
			run_done = (run_left_q == RUN_W'(1));
		end

		row_end  = run_done && (col_adv >= {{(COL_W-CFG_W){1'b0}}, cfg.sprite_width});
		row_inc  = {1'b0, row_q} + (ROW_W+1)'(1);
		column_d = row_end ? '0 : col_adv;
		if (!row_end)
			row_d = row_q;
		else if (row_inc >= {1'b0, cfg.sprite_height})
			row_d = '0;
		else
			row_d = row_inc[ROW_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q     <= '0;
			row_q        <= '0;
			run_left_q   <= '0;
			expect_hdr_q <= 1'b1;
		end else if (step) begin
			column_q     <= column_d;
			row_q        <= row_d;
			run_left_q   <= run_adv;
			expect_hdr_q <= run_done;
		end
	end

	// clip test against the destination, limited to MAX_DIM
	always_comb begin
		lim_w = (cfg.dest_width  > MAX_DIM_C) ? MAX_DIM_C : cfg.dest_width;
		lim_h = (cfg.dest_height > MAX_DIM_C) ? MAX_DIM_C : cfg.dest_height;
		dx = (COL_W+2)'(cfg.origin_x) + $signed({2'b00, column_q});
		dy = (ROW_W+2)'(cfg.origin_y) + $signed({2'b00, row_q});
		res.hit = !expect_hdr_q
			&& !dx[COL_W+1] && (dx[COL_W:0] < {{(COL_W+1-CFG_W){1'b0}}, lim_w})
			&& !dy[ROW_W+1] && (dy[ROW_W:0] < {{(ROW_W+1-CFG_W){1'b0}}, lim_h});
		res.dest_x = dx[COORD_W-1:0];
		res.dest_y = dy[COORD_W-1:0];
	end

	a_run_live: assert property (@(posedge clk) disable iff (!arst_n)
		!expect_hdr_q |-> run_left_q != '0)
		else $error("pixel expected with empty run");

	a_hdr_opens_run: assert property (@(posedge clk) disable iff (!arst_n)
		step && expect_hdr_q && word[RUN_W-1:0] != '0 |=> !expect_hdr_q)
		else $error("nonempty span header did not open a run");

	a_run_closes: assert property (@(posedge clk) disable iff (!arst_n)
		step && !expect_hdr_q && run_left_q == RUN_W'(1) |=> expect_hdr_q)
		else $error("last pixel of run did not return to header");

	a_row_wraps_col: assert property (@(posedge clk) disable iff (!arst_n)
		step && row_end |=> column_q == '0)
		else $error("row end left column nonzero");

endmodule

// ===== hw/rtl/rle_sprite_clipped_blit_core.sv =====
// rle_sprite_clipped_blit_core: top level, input stage, walker and output register.
// Depends on rlb_pkg, rlb_if, rlb_cfg_regs and rlb_walker.

// Takes the run-length coded sprite one 32-bit word per item on code and
// issues a (dest_x, dest_y, pixel_value) write on pix for each literal pixel
// that lands inside the destination; headers and clipped pixels give no item.
// One word is taken per cycle unless the input stalls. Each accepted word is
// held in the input register; when it advances, column/row/run update and the
// clip test loads the output register that drives pix. The only loop is the
// walk state update. A waiting pixel stalls the input only when the input
// register is also full. The user must write registers through cfg_write/cfg_index/
// cfg_data only while no item is in flight; the block does not enforce it.

module rle_sprite_clipped_blit_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [rlb_pkg::IDX_W-1:0] cfg_index,
	input  logic [rlb_pkg::CFG_W-1:0] cfg_data,
	rlb_code_if.sink                  code,
	rlb_pix_if.source                 pix
);
	import rlb_pkg::*;

	cfg_t      cfg;
	walk_res_t res;

	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic              advance;

	logic               pix_valid_q;
	logic [COORD_W-1:0] dest_x_q;
	logic [COORD_W-1:0] dest_y_q;
	logic [WORD_W-1:0]  pixel_q;

	rlb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rlb_walker u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.word   (word_s1),
		.res    (res)
	);

	assign advance    = valid_s1 && (!pix_valid_q || pix.ready);
	assign code.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (code.ready)
			valid_s1 <= code.valid;
	end

	always_ff @(posedge clk) begin
		if (code.ready && code.valid)
			word_s1 <= code.code_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pix_valid_q <= 1'b0;
		else if (!pix_valid_q || pix.ready)
			pix_valid_q <= advance && res.hit;
	end

	always_ff @(posedge clk) begin
		if (advance && res.hit) begin
			dest_x_q <= res.dest_x;
			dest_y_q <= res.dest_y;
			pixel_q  <= word_s1;
		end
	end

	assign pix.valid       = pix_valid_q;
	assign pix.dest_x      = dest_x_q;
	assign pix.dest_y      = dest_y_q;
	assign pix.pixel_value = pixel_q;

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(word_s1))
		else $error("stalled input stage lost its item");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid_q && !pix.ready |-> !advance)
		else $error("walker advanced into a full output register");

endmodule
